[rtl/rotating_keyed_byte_cipher_macros.svh]
// Assertion helpers shared by the cipher RTL.
// Every check is sampled on the rising edge of clk and is switched off while rst is high.
`ifndef ROTATING_KEYED_BYTE_CIPHER_MACROS_SVH
`define ROTATING_KEYED_BYTE_CIPHER_MACROS_SVH

// Same-cycle implication
`define RKBC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rkbc check failed: same-cycle implication");

// Next-cycle implication
`define RKBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rkbc check failed: next-cycle implication");

`endif

[rtl/rkbc_pkg.sv]
package rkbc_pkg;

  // Key store geometry
  localparam int KEY_LENGTH_DEF = 35;
  localparam int KEY_ROM_DEPTH  = 64;
  localparam int POS_W          = $clog2(KEY_ROM_DEPTH);

  // Configuration port widths
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ADD_OFFSET_A    = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_OFFSET_B    = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROTATE_SELECT_C = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ENCIPHER_MODE   = 8'd3;

  // Fixed bias added to plain bytes before mixing
  localparam logic [7:0] PLAIN_BIAS = 8'h40;

  // Key bytes; entries past the key text read as zero
  localparam logic [7:0] KEY_ROM [KEY_ROM_DEPTH] = '{
    0: 8'h59,  1: 8'h55,  2: 8'h4B,  3: 8'h4F,  4: 8'h5F,  5: 8'h4B,  6: 8'h41,
    7: 8'h57,  8: 8'h41,  9: 8'h49, 10: 8'h5F, 11: 8'h50, 12: 8'h55, 13: 8'h52,
    14: 8'h50, 15: 8'h4C, 16: 8'h45, 17: 8'h5F, 18: 8'h53, 19: 8'h59, 20: 8'h53,
    21: 8'h54, 22: 8'h45, 23: 8'h4D, 24: 8'h5F, 25: 8'h53, 26: 8'h41, 27: 8'h56,
    28: 8'h45, 29: 8'h5F, 30: 8'h43, 31: 8'h48, 32: 8'h45, 33: 8'h43, 34: 8'h4B,
    default: 8'h00
  };

  // Register file contents
  typedef struct packed {
    logic [7:0]  add_offset_a;
    logic [7:0]  key_offset_b;
    logic [15:0] rotate_select_c;
    logic        encipher_mode;
  } rkbc_cfg_t;

  // Item held in the input register
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic [7:0] mixed_key;
  } rkbc_item_t;

endpackage

[rtl/rkbc_in_if.sv]
// Byte stream towards the block
interface rkbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

[rtl/rkbc_out_if.sv]
// Result stream from the block
interface rkbc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  result_byte;
  logic [15:0] running_sum;
  logic        block_end;

  modport source (output valid, output result_byte, output running_sum, output block_end,
                  input ready);
  modport sink (input valid, input result_byte, input running_sum, input block_end,
                output ready);
endinterface

[rtl/rkbc_cfg_if.sv]
// Register write channel
interface rkbc_cfg_if
  import rkbc_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/rkbc_cfg_regs.sv]
module rkbc_cfg_regs
  import rkbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  rkbc_cfg_if.sink   cfg,
  output rkbc_cfg_t  regs
);

  // Writes are always taken
  assign cfg.ready = 1'b1;

  // Register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ADD_OFFSET_A:    regs.add_offset_a    <= cfg.data[7:0];
        REG_KEY_OFFSET_B:    regs.key_offset_b    <= cfg.data[7:0];
        REG_ROTATE_SELECT_C: regs.rotate_select_c <= cfg.data[15:0];
        REG_ENCIPHER_MODE:   regs.encipher_mode   <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/rkbc_in_stage.sv]
`include "rotating_keyed_byte_cipher_macros.svh"

module rkbc_in_stage
  import rkbc_pkg::*;
#(
  parameter int KEY_LENGTH = KEY_LENGTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  rkbc_in_if.sink    data_ch,
  input  rkbc_cfg_t  regs,
  output logic       item_valid,
  output rkbc_item_t item,
  input  logic       item_ready
);

  logic [POS_W-1:0] key_pos;
  logic [POS_W-1:0] key_pos_next;
  logic [POS_W:0]   pos_inc;
  logic             take;

  // Input register frees up when empty or when its item moves on
  assign data_ch.ready = !item_valid || item_ready;
  assign take          = data_ch.valid && data_ch.ready;

  // Key position: wraps at the key length, restarts after a block end
  assign pos_inc = {1'b0, key_pos} + {{POS_W{1'b0}}, 1'b1};
  always_comb begin
    if (data_ch.last_byte || (pos_inc >= (POS_W+1)'(KEY_LENGTH))) begin
      key_pos_next = '0;
    end else begin
      key_pos_next = pos_inc[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_pos    <= '0;
      item_valid <= 1'b0;
    end else begin
      if (take) begin
        key_pos <= key_pos_next;
      end
      if (take) begin
        item_valid <= 1'b1;
      end else if (item_ready) begin
        item_valid <= 1'b0;
      end
    end
  end

  // Payload: byte, flag and the key byte mixed with offset b
  always_ff @(posedge clk) begin
    if (take) begin
      item.data_byte <= data_ch.data_byte;
      item.last_byte <= data_ch.last_byte;
      item.mixed_key <= KEY_ROM[key_pos] + regs.key_offset_b;
    end
  end

  `RKBC_ASSERT_NOW(a_pos_in_range, 1'b1, ({1'b0, key_pos} < (POS_W+1)'(KEY_LENGTH)))
  `RKBC_ASSERT_NEXT(a_pos_restart, (take && data_ch.last_byte), (key_pos == '0))
  `RKBC_ASSERT_NOW(a_ready_when_empty, !item_valid, data_ch.ready)

endmodule

[rtl/rkbc_out_stage.sv]
`include "rotating_keyed_byte_cipher_macros.svh"

module rkbc_out_stage
  import rkbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  rkbc_cfg_t  regs,
  input  logic       item_valid,
  input  rkbc_item_t item,
  output logic       item_ready,
  rkbc_out_if.source result_ch
);

  logic [2:0]  rot;
  logic [15:0] sel_word;
  logic [7:0]  enc_t;
  logic [15:0] enc_rot;
  logic [15:0] dec_rot;
  logic [7:0]  dec_t;
  logic [7:0]  res;
  logic [7:0]  cipher_side;
  logic [15:0] sum;
  logic [15:0] sum_next;
  logic        move;

  // Output register takes a new result when empty or being drained
  assign item_ready = !result_ch.valid || result_ch.ready;
  assign move       = item_valid && item_ready;

  // Rotation of 2..5 from two bits of c picked by a[3:1]
  assign sel_word = regs.rotate_select_c >> regs.add_offset_a[3:1];
  assign rot      = {1'b0, sel_word[1:0]} + 3'd2;

  // Encipher: bias, mix, add a, rotate left
  assign enc_t   = ((item.data_byte + PLAIN_BIAS) ^ item.mixed_key) + regs.add_offset_a;
  assign enc_rot = {enc_t, enc_t} << rot;

  // Decipher: rotate right, subtract a, unmix, remove bias
  assign dec_rot = {item.data_byte, item.data_byte} >> rot;
  assign dec_t   = ((dec_rot[7:0] - regs.add_offset_a) ^ item.mixed_key) - PLAIN_BIAS;

  always_comb begin
    if (regs.encipher_mode) begin
      res         = enc_rot[15:8];
      cipher_side = enc_rot[15:8];
    end else begin
      res         = dec_t;
      cipher_side = item.data_byte;
    end
  end

  // Checksum over the ciphered side
  assign sum_next = sum + {8'h00, cipher_side};

  always_ff @(posedge clk) begin
    if (rst) begin
      sum             <= '0;
      result_ch.valid <= 1'b0;
    end else begin
      if (move) begin
        sum <= item.last_byte ? 16'h0000 : sum_next;
      end
      if (move) begin
        result_ch.valid <= 1'b1;
      end else if (result_ch.ready) begin
        result_ch.valid <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (move) begin
      result_ch.result_byte <= res;
      result_ch.running_sum <= sum_next;
      result_ch.block_end   <= item.last_byte;
    end
  end

  `RKBC_ASSERT_NEXT(a_sum_cleared, (move && item.last_byte), (sum == 16'h0000))
  `RKBC_ASSERT_NEXT(a_result_loaded, move, result_ch.valid)
  `RKBC_ASSERT_NEXT(a_drained_empty, (result_ch.valid && result_ch.ready && !move),
                    !result_ch.valid)

endmodule

[rtl/rotating_keyed_byte_cipher.sv]
// Keyed byte cipher with a running 16-bit checksum.
// data_ch carries data_byte and last_byte; result_ch returns result_byte,
// running_sum and block_end. Both are valid/ready streams; a transfer happens
// on a rising edge with valid and ready high. cfg writes registers by index:
// 0 add_offset_a, 1 key_offset_b, 2 rotate_select_c, 3 encipher_mode; other
// indexes are ignored. Write registers only while the stream is idle.
// A byte passes through the input register and then the result register.
// Throughput: one byte per cycle while result_ch is ready; the input register
// and the result register each hold one item, so one more byte enters while a result waits.
// When result_ch stalls, the result register holds and the input register
// fills; data_ch.ready drops only once both are occupied.
// Reset (rst, synchronous) clears the config registers to zero, empties both stages
// and sets the key position and checksum to zero. A byte with last_byte set
// closes the block: its result has block_end set and the final sum, after
// which the key position and checksum start again from zero.
module rotating_keyed_byte_cipher
  import rkbc_pkg::*;
#(
  parameter int KEY_LENGTH = KEY_LENGTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  rkbc_cfg_if.sink   cfg,
  rkbc_in_if.sink    data_ch,
  rkbc_out_if.source result_ch
);

  rkbc_cfg_t  regs;
  rkbc_item_t item;
  logic       item_valid;
  logic       item_ready;

  rkbc_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  rkbc_in_stage #(
    .KEY_LENGTH (KEY_LENGTH)
  ) u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .data_ch    (data_ch),
    .regs       (regs),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready)
  );

  rkbc_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .result_ch  (result_ch)
  );

endmodule

[sim/rotating_keyed_byte_cipher_tb.sv]
`timescale 1ns / 100ps

module rotating_keyed_byte_cipher_tb;
  import rkbc_pkg::*;

  localparam int KEY_LEN       = KEY_LENGTH_DEF;
  localparam int KEY_TEXT_LEN  = 35;
  // Key text as bytes, first character first
  localparam logic [7:0] KEY_BYTES [KEY_TEXT_LEN] = '{
    8'h59, 8'h55, 8'h4B, 8'h4F, 8'h5F, 8'h4B, 8'h41, 8'h57, 8'h41, 8'h49,
    8'h5F, 8'h50, 8'h55, 8'h52, 8'h50, 8'h4C, 8'h45, 8'h5F, 8'h53, 8'h59,
    8'h53, 8'h54, 8'h45, 8'h4D, 8'h5F, 8'h53, 8'h41, 8'h56, 8'h45, 8'h5F,
    8'h43, 8'h48, 8'h45, 8'h43, 8'h4B
  };
  localparam logic [7:0] PLAIN_OFFSET = 8'h40;
  localparam logic [CFG_INDEX_W-1:0] REG_INDEX_UNUSED = 8'hA5;
  localparam int REGIME_ITEMS   = 35;
  localparam int HOLD_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int WRAP_BLOCK_LEN = 270;

  typedef struct packed {
    logic [7:0]  result_byte;
    logic [15:0] running_sum;
    logic        block_end;
  } cipher_result_t;

  // Tracks register contents, key position and checksum; holds due results
  class cipher_scoreboard;
    logic [7:0]     byte_add;
    logic [7:0]     key_add;
    logic [15:0]    rot_sel;
    logic           encipher;
    int             key_pos;
    logic [15:0]    checksum;
    cipher_result_t results_due[$];
    int             mismatches;

    function new();
      byte_add   = '0;
      key_add    = '0;
      rot_sel    = '0;
      encipher   = 1'b0;
      key_pos    = 0;
      checksum   = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_ADD_OFFSET_A: begin
          byte_add = value[7:0];
        end
        REG_KEY_OFFSET_B: begin
          key_add = value[7:0];
        end
        REG_ROTATE_SELECT_C: begin
          rot_sel = value[15:0];
        end
        REG_ENCIPHER_MODE: begin
          encipher = value[0];
        end
        default: begin
        end
      endcase
    endfunction

    function logic [7:0] key_byte(int pos);
      if (pos < KEY_TEXT_LEN) begin
        return KEY_BYTES[6'(pos)];
      end
      return 8'h00;
    endfunction

    // Two bits of the select word, picked by a[3:1], plus two; capped at six
    function int rotation();
      logic [15:0] shifted;
      int          r;
      shifted = rot_sel >> byte_add[3:1];
      r = int'(shifted[1:0]) + 2;
      if (r > 6) begin
        r = 6;
      end
      return r;
    endfunction

    // Accepted input byte: work out its result and advance the state
    function void note_byte(logic [7:0] value, logic last);
      logic [7:0]  mixed;
      logic [7:0]  t;
      logic [7:0]  res;
      logic [7:0]  cipher_side;
      logic [15:0] wide;
      int          r;
      r = rotation();
      mixed = key_byte(key_pos) + key_add;
      if (encipher) begin
        t = value + PLAIN_OFFSET;
        t = t ^ mixed;
        t = t + byte_add;
        wide = {t, t} << r;
        res = wide[15:8];
        cipher_side = res;
      end else begin
        wide = {value, value} >> r;
        t = wide[7:0] - byte_add;
        t = t ^ mixed;
        res = t - PLAIN_OFFSET;
        cipher_side = value;
      end
      checksum = checksum + {8'h00, cipher_side};
      results_due.push_back('{res, checksum, last});
      if (key_pos + 1 >= KEY_LEN) begin
        key_pos = 0;
      end else begin
        key_pos = key_pos + 1;
      end
      if (last) begin
        key_pos  = 0;
        checksum = '0;
      end
    endfunction

    function void check_result(logic [7:0] res, logic [15:0] total, logic end_flag);
      cipher_result_t want;
      if (results_due.size() == 0) begin
        $error("result transfer with nothing due: result_byte %0h", res);
        mismatches++;
        return;
      end
      want = results_due.pop_front();
      if (res !== want.result_byte) begin
        $error("result_byte: expected %0h, actual %0h", want.result_byte, res);
        mismatches++;
      end
      if (total !== want.running_sum) begin
        $error("running_sum: expected %0h, actual %0h", want.running_sum, total);
        mismatches++;
      end
      if (end_flag !== want.block_end) begin
        $error("block_end: expected %0b, actual %0b", want.block_end, end_flag);
        mismatches++;
      end
    endfunction

    function int pending();
      return results_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic hold_go;
  int   send_pct;
  int   recv_pct;
  int   block_left;

  cipher_scoreboard book = new();

  rkbc_cfg_if cfg();
  rkbc_in_if  data_ch();
  rkbc_out_if result_ch();

  rotating_keyed_byte_cipher u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .data_ch   (data_ch),
    .result_ch (result_ch)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Observe transfers on all three channels
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg.valid && cfg.ready) begin
        book.write_reg(cfg.index, cfg.data);
      end
      if (data_ch.valid && data_ch.ready) begin
        book.note_byte(data_ch.data_byte, data_ch.last_byte);
      end
      if (result_ch.valid && result_ch.ready) begin
        book.check_result(result_ch.result_byte, result_ch.running_sum,
                          result_ch.block_end);
      end
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request
  initial begin
    int  held;
    bit  hold_done;
    held = 0;
    hold_done = 1'b0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        result_ch.ready <= 1'b0;
        held++;
        if (held >= HOLD_CYCLES) begin
          hold_done = 1'b1;
        end
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_pct);
      end
    end
  end

  // Ends the run if nothing transfers for too long
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((cfg.valid && cfg.ready) || (data_ch.valid && data_ch.ready) ||
          (result_ch.valid && result_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // One register write; valid stays high for a following write
  task automatic put_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
  endtask

  // Full register set, with junk in the unused upper bits and a stray index
  task automatic write_regs(logic [7:0] a, logic [7:0] b, logic [15:0] c, logic mode);
    put_reg(REG_INDEX_UNUSED, 16'($urandom));
    put_reg(REG_ADD_OFFSET_A, {8'($urandom), a});
    put_reg(REG_KEY_OFFSET_B, {8'($urandom), b});
    put_reg(REG_ROTATE_SELECT_C, c);
    put_reg(REG_ENCIPHER_MODE, {15'($urandom), mode});
    cfg.valid <= 1'b0;
  endtask

  task automatic send_byte(logic [7:0] value, logic last);
    while ($urandom_range(99) < send_pct) begin
      data_ch.valid <= 1'b0;
      @(posedge clk);
    end
    data_ch.valid     <= 1'b1;
    data_ch.data_byte <= value;
    data_ch.last_byte <= last;
    do @(posedge clk); while (!data_ch.ready);
  endtask

  // Random bytes in blocks of random length; short and long blocks mixed
  task automatic send_stream(int count);
    for (int k = 0; k < count; k++) begin
      if (block_left == 0) begin
        block_left = ($urandom_range(3) == 0) ? $urandom_range(36, 80) : $urandom_range(1, 34);
      end
      block_left--;
      send_byte(8'($urandom_range(255)), block_left == 0);
    end
  endtask

  // Stop offering and wait for every due result, then a little longer
  task automatic wait_idle();
    data_ch.valid <= 1'b0;
    do @(posedge clk); while (book.pending() != 0);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_value(logic [15:0] max_value);
    case ($urandom_range(3))
      0: return '0;
      1: return max_value;
      default: return 16'($urandom) & max_value;
    endcase
  endfunction

  task automatic random_setup(logic mode);
    write_regs(8'(pick_value(16'h00FF)), 8'(pick_value(16'h00FF)), pick_value(16'hFFFF), mode);
  endtask

  initial begin
    int done_items;
    int n;
    rst               <= 1'b1;
    hold_go           <= 1'b0;
    send_pct          <= 0;
    recv_pct          <= 0;
    block_left         = 0;
    cfg.valid         <= 1'b0;
    cfg.index         <= '0;
    cfg.data          <= '0;
    data_ch.valid     <= 1'b0;
    data_ch.data_byte <= '0;
    data_ch.last_byte <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers as left by reset: decipher, no offsets, rotation of two
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    wait_idle();

    // All registers at their maximum, enciphering; two blocks back to back
    write_regs(8'hFF, 8'hFF, 16'hFFFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_idle();

    // Enciphering with everything at zero
    write_regs(8'h00, 8'h00, 16'h0000, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_idle();

    // Top select shift, deciphering
    write_regs(8'h0E, 8'h80, 16'hC000, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h12, 1'b1);
    wait_idle();

    // Rotation by three, enciphering
    write_regs(8'h02, 8'h01, 16'h0002, 1'b1);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b1);
    wait_idle();

    // Rotation by four, deciphering
    write_regs(8'h02, 8'h7F, 16'h0004, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b1);
    wait_idle();

    // Random part: three idling regimes, a fresh register set per phase
    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin
          send_pct <= 13;
          recv_pct <= 71;
        end
        1: begin
          send_pct <= 71;
          recv_pct <= 13;
        end
        default: begin
          send_pct <= 0;
          recv_pct <= 0;
        end
      endcase
      done_items = 0;
      while (done_items < REGIME_ITEMS) begin
        n = $urandom_range(15, 45);
        random_setup(1'($urandom_range(1)));
        // Long result-side hold while bytes keep coming, to fill the block
        if (regime == 2 && done_items == 0) begin
          hold_go <= 1'b1;
        end
        send_stream(n);
        wait_idle();
        done_items += n;
      end
    end

    // Long deciphered block of high bytes so the checksum wraps
    random_setup(1'b0);
    for (int k = 0; k < WRAP_BLOCK_LEN; k++) begin
      send_byte(8'hFE | 8'($urandom_range(1)), k == WRAP_BLOCK_LEN - 1);
    end
    block_left = 0;
    wait_idle();
    repeat (5) @(posedge clk);

    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
